// ----- rtl/core/spfe_pkg.sv -----
// Shared constants and the job record passed from the front end to the back end.
`timescale 1ns / 1ps

package spfe_pkg;

    localparam int DEFAULT_PAYLOAD_BYTES = 24;
    localparam int QUEUE_DEPTH           = 2;

    localparam logic [7:0] START_CODE   = 8'h02;
    localparam logic [7:0] END_CODE     = 8'h03;
    localparam logic [1:0] PRINT_TAG    = 2'b01;
    localparam logic [5:0] HEADER_RESET = 6'd4;

    // One accepted byte turns into one to three characters.
    typedef struct packed {
        logic [7:0] ch0;
        logic [7:0] ch1;
        logic [7:0] ch2;
        logic [1:0] last_idx;
        logic       has_end;
    } job_t;

endpackage

// ----- rtl/core/spfe_front.sv -----
// Front end: accepts payload bytes, tracks frame state and builds character jobs.
`timescale 1ns / 1ps

module spfe_front #(
    parameter int PAYLOAD_BYTES = spfe_pkg::DEFAULT_PAYLOAD_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              q_full,
    input  logic [7:0]        payload_byte,
    input  logic              cfg_we,
    input  logic [5:0]        cfg_wdata,
    output logic              job_push,
    output spfe_pkg::job_t    job
);
    import spfe_pkg::*;

    localparam int POS_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PAYLOAD_BYTES - 1);

    logic [5:0]       header_reg;
    logic [1:0]       phase_reg,  phase_next;
    logic [3:0]       left_reg,   left_next;
    logic [POS_W-1:0] pos_reg,    pos_next;

    logic       accept;
    logic       first, last;
    logic [1:0] ph;
    logic [3:0] lo;
    logic [7:0] d0, d1, pad;
    logic [1:0] ph_after;
    logic [3:0] lo_after;

    assign accept   = push && !q_full;
    assign job_push = accept;
    assign first    = (pos_reg == '0);
    assign last     = (pos_reg == LAST_POS);
    assign ph       = first ? 2'd0 : phase_reg;
    assign lo       = first ? 4'd0 : left_reg;

    always_comb
    begin
        d1 = {PRINT_TAG, payload_byte[5:0]};
        unique case (ph)
            2'd1:
            begin
                d0       = {PRINT_TAG, lo[1:0], payload_byte[7:4]};
                ph_after = 2'd2;
                lo_after = payload_byte[3:0];
            end
            2'd2:
            begin
                d0       = {PRINT_TAG, lo[3:0], payload_byte[7:6]};
                ph_after = 2'd0;
                lo_after = 4'd0;
            end
            default:
            begin
                d0       = {PRINT_TAG, payload_byte[7:2]};
                ph_after = 2'd1;
                lo_after = {2'b00, payload_byte[1:0]};
            end
        endcase
        // pending bits at frame end go out zero-padded at the low end
        pad = (ph_after == 2'd1) ? {PRINT_TAG, lo_after[1:0], 4'b0000}
                                 : {PRINT_TAG, lo_after[3:0], 2'b00};
    end

    // Frames must be at least three bytes (the block does not enforce it), so first and last never coincide.
    always_comb
    begin
        job = '0;
        priority if (first)
        begin
            job.ch0      = START_CODE;
            job.ch1      = {2'b00, header_reg};
            job.ch2      = d0;
            job.last_idx = 2'd2;
        end
        else if (last)
        begin
            job.ch0      = d0;
            job.ch1      = (ph == 2'd2) ? d1 : pad;
            job.ch2      = END_CODE;
            job.last_idx = 2'd2;
            job.has_end  = 1'b1;
        end
        else
        begin
            job.ch0      = d0;
            job.ch1      = d1;
            job.ch2      = END_CODE;
            job.last_idx = (ph == 2'd2) ? 2'd1 : 2'd0;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        pos_next   = pos_reg;
        if (accept)
        begin
            if (last)
            begin
                phase_next = 2'd0;
                left_next  = 4'd0;
                pos_next   = '0;
            end
            else
            begin
                phase_next = ph_after;
                left_next  = lo_after;
                pos_next   = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RESET;
            phase_reg  <= 2'd0;
            left_reg   <= 4'd0;
            pos_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                header_reg <= cfg_wdata;
            end
            phase_reg <= phase_next;
            left_reg  <= left_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

// ----- rtl/core/spfe_queue.sv -----
// Short job queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module spfe_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  spfe_pkg::job_t    wr_job,
    output logic              q_full,
    input  logic              rd_en,
    output logic              rd_valid,
    output spfe_pkg::job_t    rd_job
);
    import spfe_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

    job_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_wr, do_rd;

    assign q_full   = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_job   = mem[rptr_reg];
    assign do_wr    = wr_en && !q_full;
    assign do_rd    = rd_en && rd_valid;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= (wptr_reg == LAST_SLOT) ? '0 : wptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rptr_reg <= (rptr_reg == LAST_SLOT) ? '0 : rptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/spfe_back.sv -----
// Back end: walks each job one character per cycle into the output register while the receiver pops.
`timescale 1ns / 1ps

module spfe_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  spfe_pkg::job_t    job,
    output logic              job_pop,
    output logic              empty,
    input  logic              pop,
    output logic [7:0]        char_out,
    output logic              frame_end,
    output logic              run_last
);
    import spfe_pkg::*;

    logic [1:0] idx_reg;
    logic       out_valid_reg;
    logic [7:0] char_reg;
    logic       end_reg;
    logic       last_reg;
    logic       load;
    logic       at_last;
    logic [7:0] sel_char;

    assign load    = job_valid && (!out_valid_reg || pop);
    assign at_last = (idx_reg == job.last_idx);
    assign job_pop = load && at_last;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    sel_char = job.ch0;
            2'd1:    sel_char = job.ch1;
            default: sel_char = job.ch2;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= sel_char;
            end_reg  <= job.has_end && at_last;
            last_reg <= at_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= at_last ? 2'd0 : idx_reg + 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty     = !out_valid_reg;
    assign char_out  = char_reg;
    assign frame_end = end_reg;
    assign run_last  = last_reg;

endmodule

// ----- rtl/core/six_bit_printable_frame_encoder.sv -----
// Top level: printable six-bit frame encoder with start/end codes.
//
// Input channel: payload_byte is taken on a rising edge with push high and
// full low. Bytes are the payload of fixed frames of PAYLOAD_BYTES bytes.
// Output channel: while empty is low, char_out/frame_end/run_last show the
// oldest character; it is taken on an edge with pop high. run_last marks the
// last character caused by a byte, frame_end marks the end code.
// Config: cfg_we writes cfg_wdata into the header register (reset 4); it is
// sampled by the first byte of a frame.
// Flow: a byte's job is written into the job queue and then loaded into the
// output register once that register is free. The front end takes a byte every
// cycle while the two-entry job queue has room; the back end sends one
// character per cycle while pop is high, so the rate is set by the output
// register: 1 to 3 characters per byte (35 characters per 24-byte frame at the
// default length).
// Reset clears frame state, the queue and the output register. When the
// receiver stalls, the output holds, the queue fills and full rises.
`timescale 1ns / 1ps

module six_bit_printable_frame_encoder #(
    parameter int PAYLOAD_BYTES = spfe_pkg::DEFAULT_PAYLOAD_BYTES
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] payload_byte,
    input  logic       cfg_we,
    input  logic [5:0] cfg_wdata,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] char_out,
    output logic       frame_end,
    output logic       run_last
);
    import spfe_pkg::*;

    job_t wr_job, rd_job;
    logic job_push, job_pop, job_valid, q_full;

    assign full = q_full;

    spfe_front #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .q_full       (q_full),
        .payload_byte (payload_byte),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .job_push     (job_push),
        .job          (wr_job)
    );

    spfe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_push),
        .wr_job   (wr_job),
        .q_full   (q_full),
        .rd_en    (job_pop),
        .rd_valid (job_valid),
        .rd_job   (rd_job)
    );

    spfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (rd_job),
        .job_pop   (job_pop),
        .empty     (empty),
        .pop       (pop),
        .char_out  (char_out),
        .frame_end (frame_end),
        .run_last  (run_last)
    );

endmodule

// ----- rtl/core/spfe_checker.sv -----
// Port-level checker for the frame encoder, bound to the top level.
`timescale 1ns / 1ps

module spfe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] char_out,
    input logic       frame_end,
    input logic       run_last
);
    import spfe_pkg::*;

    // held character stays put until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(char_out) && $stable(run_last)))
        else $error("output changed while stalled");

    a_end_code: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_end) |-> (char_out == END_CODE && run_last))
        else $error("frame end without end code or not last");

    // start and header characters never close a byte's run
    a_ctrl_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && char_out[7:6] == 2'b00 && !frame_end) |-> !run_last)
        else $error("start or header marked as last");

    a_data_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && char_out[7:6] != 2'b00) |-> (char_out[7:6] == PRINT_TAG && !frame_end))
        else $error("data character outside printable range");

endmodule

bind six_bit_printable_frame_encoder spfe_checker u_spfe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .char_out  (char_out),
    .frame_end (frame_end),
    .run_last  (run_last)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for the six-bit printable frame encoder.
`timescale 1ns / 1ps

module testbench;

    import spfe_pkg::*;

    // frames of the default length; a 24-byte frame ends on a full triple
    localparam int FRAME_BYTES  = DEFAULT_PAYLOAD_BYTES;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [7:0] ch;
        logic       frame_end;
        logic       run_last;
    } enc_char_t;

    class char_scoreboard;
        logic [5:0] header_reg;
        logic [1:0] phase;
        logic [3:0] held_bits;
        int         frame_pos;
        int         frame_len;
        enc_char_t  pending_chars[$];
        int         error_count;
        int         chars_checked;
        int         frames_closed;

        function new(int len);
            frame_len     = len;
            header_reg    = HEADER_RESET;
            phase         = 2'd0;
            held_bits     = 4'd0;
            frame_pos     = 0;
            error_count   = 0;
            chars_checked = 0;
            frames_closed = 0;
        endfunction

        function void set_header(logic [5:0] value);
            header_reg = value;
        endfunction

        function void emit(logic [7:0] ch, logic is_end);
            enc_char_t c;
            c.ch        = ch;
            c.frame_end = is_end;
            c.run_last  = 1'b0;
            pending_chars.push_back(c);
        endfunction

        // Expected characters for one accepted payload byte.
        function void encode_byte(logic [7:0] b);
            if (frame_pos == 0)
            begin
                phase     = 2'd0;
                held_bits = 4'd0;
                emit(START_CODE, 1'b0);
                emit({2'b00, header_reg}, 1'b0);
            end
            case (phase)
                2'd0:
                begin
                    emit({PRINT_TAG, b[7:2]}, 1'b0);
                    held_bits = {2'b00, b[1:0]};
                    phase     = 2'd1;
                end
                2'd1:
                begin
                    emit({PRINT_TAG, held_bits[1:0], b[7:4]}, 1'b0);
                    held_bits = b[3:0];
                    phase     = 2'd2;
                end
                default:
                begin
                    emit({PRINT_TAG, held_bits, b[7:6]}, 1'b0);
                    emit({PRINT_TAG, b[5:0]}, 1'b0);
                    held_bits = 4'd0;
                    phase     = 2'd0;
                end
            endcase
            frame_pos++;
            if (frame_pos >= frame_len)
            begin
                // pending bits go out zero-padded before the end code
                if (phase == 2'd1)
                    emit({PRINT_TAG, held_bits[1:0], 4'b0000}, 1'b0);
                else if (phase == 2'd2)
                    emit({PRINT_TAG, held_bits, 2'b00}, 1'b0);
                emit(END_CODE, 1'b1);
                frame_pos = 0;
                phase     = 2'd0;
                held_bits = 4'd0;
                frames_closed++;
            end
            pending_chars[pending_chars.size() - 1].run_last = 1'b1;
        endfunction

        function void report(string what, logic [7:0] want, logic [7:0] got);
            error_count++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
        endfunction

        function void check_char(logic [7:0] ch, logic fe, logic rl);
            enc_char_t want;
            if (pending_chars.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected character: expected none, actual %h (end %b last %b)",
                         $time, ch, fe, rl);
                return;
            end
            want = pending_chars.pop_front();
            chars_checked++;
            if (want.ch !== ch)
                report("char_out", want.ch, ch);
            if (want.frame_end !== fe)
                report("frame_end", {7'd0, want.frame_end}, {7'd0, fe});
            if (want.run_last !== rl)
                report("run_last", {7'd0, want.run_last}, {7'd0, rl});
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] payload_byte;
    logic       cfg_we;
    logic [5:0] cfg_wdata;
    logic       empty;
    logic       pop;
    logic [7:0] char_out;
    logic       frame_end;
    logic       run_last;

    char_scoreboard board;
    int             send_idle_pct;
    int             recv_idle_pct;
    int             bytes_sent;
    int             quiet_cycles;
    logic [5:0]     last_header;

    logic [7:0] directed_bytes[25] = '{
        8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h80,
        8'h01, 8'h3F, 8'hC0, 8'h7F, 8'hFE, 8'h0F, 8'hF0, 8'h03, 8'hFC,
        8'h30, 8'h0C, 8'hC3, 8'h5A, 8'hA5, 8'h02, 8'h40
    };

    six_bit_printable_frame_encoder #(
        .PAYLOAD_BYTES (FRAME_BYTES)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .payload_byte (payload_byte),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .empty        (empty),
        .pop          (pop),
        .char_out     (char_out),
        .frame_end    (frame_end),
        .run_last     (run_last)
    );

    always #1 clk = ~clk;

    // receiver: random stalls, decided at each falling edge
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result check and watchdog on transfers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                board.check_char(char_out, frame_end, run_last);
            if ((pop && !empty) || (push && !full))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("%0t: no transfer for %0d cycles, %0d characters outstanding",
                             $time, QUIET_LIMIT, board.pending_chars.size());
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end
        end
    end

    // Returns at the falling edge after the transfer with push still high.
    task automatic send_byte(input logic [7:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push         <= 1'b1;
        payload_byte <= value;
        @(posedge clk);
        while (full)
            @(posedge clk);
        board.encode_byte(value);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic run_random(input int count);
        logic [7:0] value;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 7))
                0:       value = 8'h00;
                1:       value = 8'hFF;
                default: value = 8'($urandom_range(0, 255));
            endcase
            send_byte(value);
        end
        push <= 1'b0;
    endtask

    task automatic wait_drained();
        while (board.pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // header write only with nothing in flight; may land mid-frame
    task automatic load_header(input logic [5:0] value);
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.set_header(value);
        last_header = value;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        push          = 1'b0;
        payload_byte  = 8'h00;
        cfg_we        = 1'b0;
        cfg_wdata     = 6'd0;
        bytes_sent    = 0;
        quiet_cycles  = 0;
        send_idle_pct = 8;
        recv_idle_pct = 53;
        board         = new(FRAME_BYTES);
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // a frame of edge patterns with the reset header, one byte into the next
        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);
        push <= 1'b0;

        load_header(6'd0);
        run_random(120);

        send_idle_pct = 53;
        recv_idle_pct = 8;
        load_header(6'd63);
        run_random(120);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_header(6'($urandom_range(1, 62)));
        run_random(115);

        wait_drained();

        $display("Sent %0d payload bytes (%0d frames closed), checked %0d characters.",
                 bytes_sent, board.frames_closed, board.chars_checked);
        $display("Headers 4, 0, 63 and %0d; idle mix 8/53, 53/8 and 0/0 percent.",
                 last_header);
        if (board.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- six_bit_printable_frame_encoder.f -----
rtl/core/spfe_pkg.sv
rtl/core/spfe_front.sv
rtl/core/spfe_queue.sv
rtl/core/spfe_back.sv
rtl/core/six_bit_printable_frame_encoder.sv
rtl/core/spfe_checker.sv
tb/testbench.sv
